/* rtl/core/tod_pkg.sv */
package tod_pkg;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned PORT_W   = 3;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned SUM_W    = 16;

  localparam int unsigned THRESH_FACTOR = 18;
  // widest value of THRESH_FACTOR * set current + 1
  localparam int unsigned THR_BASE_W = 21;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_CALIBRATE = 1'b1;

  typedef enum logic [1:0] {
    REG_SENSE_MODE   = 2'd0,
    REG_SET_CURRENT  = 2'd1,
    REG_FREE_TO_SET  = 2'd2,
    REG_SET_TO_FREE  = 2'd3
  } cfg_reg_t;

  localparam logic             SENSE_MODE_RST    = 1'b1;
  localparam logic [CFG_W-1:0] SET_CURRENT_RST   = 16'd10;
  localparam logic [CFG_W-1:0] FREE_TO_SET_RST   = 16'd10;
  localparam logic [CFG_W-1:0] SET_TO_FREE_RST   = 16'd1000;

endpackage

/* rtl/core/tod_in_if.sv */
interface tod_in_if
  import tod_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [PORT_W-1:0]   port;
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, func, port, sample, now_ms, input ready);
  modport sink (input valid, func, port, sample, now_ms, output ready);
endinterface

/* rtl/core/tod_out_if.sv */
interface tod_out_if
  import tod_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              report_valid;
  logic [PORT_W-1:0] report_port;
  logic              occupied;

  modport source (output valid, report_valid, report_port, occupied, input ready);
  modport sink (input valid, report_valid, report_port, occupied, output ready);
endinterface

/* rtl/core/track_occupancy_detector.sv */
// An accepted input word passes through the input register, then the result register,
// to its result word; one result word per input word.
// Throughput: one word per cycle unless a low out_ch.ready stalls the result; the per-section
// tables are read, updated and written back between the input and result registers.
// Reset (rst_n low, synchronous): registers return to their reset values, every section
// is free with nothing pending, offsets, sums and counts are zero, both stages empty.
module track_occupancy_detector
  import tod_pkg::*;
#(
  parameter int unsigned PORTS   = 8,
  parameter int unsigned SAMPLES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  tod_in_if.sink           in_ch,
  tod_out_if.source        out_ch,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned THR_W = THR_BASE_W + CNT_W;

  // ---------------- configuration ----------------
  logic             sense_mode_r;
  logic [CFG_W-1:0] free_to_set_r;
  logic [CFG_W-1:0] set_to_free_r;
  // SAMPLES * (THRESH_FACTOR * set current + 1): sum reaching it means average above threshold
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sense_mode_r  <= SENSE_MODE_RST;
      free_to_set_r <= FREE_TO_SET_RST;
      set_to_free_r <= SET_TO_FREE_RST;
      thr_r         <= THR_W'(SAMPLES) *
                       (THR_W'(SET_CURRENT_RST) * THR_W'(THRESH_FACTOR) + THR_W'(1));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSE_MODE:  sense_mode_r  <= cfg_wdata[0];
        REG_SET_CURRENT: thr_r         <= THR_W'(SAMPLES) *
                                          (THR_W'(cfg_wdata) * THR_W'(THRESH_FACTOR)
                                           + THR_W'(1));
        REG_FREE_TO_SET: free_to_set_r <= cfg_wdata;
        REG_SET_TO_FREE: set_to_free_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // input register
  logic [FUNC_W-1:0]   func_r;
  logic [PORT_W-1:0]   port_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]   now_r;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r   <= in_ch.func;
      port_r   <= in_ch.port;
      sample_r <= in_ch.sample;
      now_r    <= in_ch.now_ms;
    end
  end

  // ---------------- per-section tables ----------------
  logic [SAMPLE_W-1:0] offset_r   [PORTS];
  logic [SUM_W-1:0]    dev_sum_r  [PORTS];
  logic [CNT_W-1:0]    cnt_r      [PORTS];
  logic                raw_r      [PORTS];
  logic                reported_r [PORTS];
  logic [TIME_W-1:0]   chg_time_r [PORTS];

  logic [IDX_W-1:0] idx;
  logic             in_range;
  assign idx      = IDX_W'(port_r);
  assign in_range = 32'(port_r) < PORTS;

  // current-sense accumulation
  logic [SAMPLE_W-1:0] off;
  logic [SAMPLE_W-1:0] dev;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic [CNT_W-1:0]    cnt_inc;
  logic                avg_done;

  assign off      = offset_r[idx];
  assign dev      = (sample_r > off) ? (sample_r - off) : (off - sample_r);
  assign sum_wide = {1'b0, dev_sum_r[idx]} + (SUM_W + 1)'(dev);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign cnt_inc  = cnt_r[idx] + CNT_W'(1);
  assign avg_done = cnt_inc >= CNT_W'(SAMPLES);

  // debounce
  logic              do_sample;
  logic              do_qualify;
  logic              st;
  logic              changed;
  logic              rep_eff;
  logic [TIME_W-1:0] ct_eff;
  logic [CFG_W-1:0]  hold;
  logic [TIME_W-1:0] deadline;
  logic              fire;

  assign do_sample  = in_range && (func_r == FUNC_SAMPLE);
  assign do_qualify = do_sample && (!sense_mode_r || avg_done);
  assign st         = sense_mode_r ? (THR_W'(sum_sat) >= thr_r) : sample_r[0];
  assign changed    = st != raw_r[idx];
  assign rep_eff    = changed ? 1'b0 : reported_r[idx];
  assign ct_eff     = changed ? now_r : chg_time_r[idx];
  assign hold       = st ? free_to_set_r : set_to_free_r;
  assign deadline   = ct_eff + TIME_W'(hold);
  assign fire       = do_qualify && !rep_eff && (deadline < now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORTS; i++) begin
        offset_r[i]   <= '0;
        dev_sum_r[i]  <= '0;
        cnt_r[i]      <= '0;
        raw_r[i]      <= 1'b0;
        reported_r[i] <= 1'b1;
        chg_time_r[i] <= '0;
      end
    end else if (s1_adv && in_range) begin
      if (func_r == FUNC_CALIBRATE) begin
        offset_r[idx] <= sample_r;
      end else begin
        if (sense_mode_r) begin
          dev_sum_r[idx] <= avg_done ? '0 : sum_sat;
          cnt_r[idx]     <= avg_done ? '0 : cnt_inc;
        end
        if (do_qualify) begin
          raw_r[idx]      <= st;
          chg_time_r[idx] <= ct_eff;
          reported_r[idx] <= rep_eff || fire;
        end
      end
    end
  end

  // ---------------- result register ----------------
  logic              rpt_valid_r;
  logic [PORT_W-1:0] rpt_port_r;
  logic              occupied_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rpt_valid_r <= fire;
      rpt_port_r  <= fire ? port_r : '0;
      occupied_r  <= fire && st;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.report_valid = rpt_valid_r;
  assign out_ch.report_port  = rpt_port_r;
  assign out_ch.occupied     = occupied_r;

endmodule

/* test/tb_track_occupancy_detector.sv */
`timescale 1ns / 100ps

module tb_track_occupancy_detector
  import tod_pkg::*;
  ();

  localparam int unsigned SECTIONS   = 8;
  localparam int unsigned AVG_LENGTH = 16;

  typedef struct packed {
    logic              report_valid;
    logic [PORT_W-1:0] report_port;
    logic              occupied;
  } report_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  tod_in_if  in_ch ();
  tod_out_if out_ch ();

  track_occupancy_detector #(
    .PORTS   (SECTIONS),
    .SAMPLES (AVG_LENGTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the detector: config registers and per-section tables
  logic                mode_sense;
  logic [CFG_W-1:0]    thr_current;
  logic [CFG_W-1:0]    hold_set;
  logic [CFG_W-1:0]    hold_free;
  logic [SAMPLE_W-1:0] sect_offset [SECTIONS];
  logic [SUM_W-1:0]    sect_sum    [SECTIONS];
  int unsigned         sect_count  [SECTIONS];
  logic                sect_raw    [SECTIONS];
  logic                sect_settled[SECTIONS];
  logic [TIME_W-1:0]   sect_stamp  [SECTIONS];

  report_t           pending_reports[$];
  int                err_count;
  bit                no_idle;
  logic [TIME_W-1:0] clock_ms;
  bit [SECTIONS-1:0] sect_goal;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic debounce(logic [PORT_W-1:0] port, logic level,
                                    logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] due;
    if (level != sect_raw[port]) begin
      sect_settled[port] = 1'b0;
      sect_raw[port]     = level;
      sect_stamp[port]   = now;
    end
    if (sect_settled[port]) return 1'b0;
    hold = level ? TIME_W'(hold_set) : TIME_W'(hold_free);
    due  = sect_stamp[port] + hold;  // wraps at 32 bits
    if (due < now) begin
      sect_settled[port] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic report_t predict_report(logic [FUNC_W-1:0] func,
                                             logic [PORT_W-1:0] port,
                                             logic [SAMPLE_W-1:0] smp,
                                             logic [TIME_W-1:0] now);
    report_t             r;
    logic                level;
    logic                decide;
    logic [SAMPLE_W-1:0] off;
    logic [SAMPLE_W-1:0] dev;
    logic [SUM_W:0]      acc;
    r      = '0;
    level  = 1'b0;
    decide = 1'b0;
    if (func == FUNC_CALIBRATE) begin
      sect_offset[port] = smp;
      return r;
    end
    if (!mode_sense) begin
      level  = smp[0];
      decide = 1'b1;
    end else begin
      off = sect_offset[port];
      dev = (smp > off) ? smp - off : off - smp;
      acc = {1'b0, sect_sum[port]} + (SUM_W+1)'(dev);
      if (acc > (SUM_W+1)'(SUM_MAX)) acc = (SUM_W+1)'(SUM_MAX);
      sect_sum[port]   = acc[SUM_W-1:0];
      sect_count[port] = sect_count[port] + 1;
      if (sect_count[port] >= AVG_LENGTH) begin
        level = (32'(sect_sum[port]) / AVG_LENGTH) > (THRESH_FACTOR * 32'(thr_current));
        sect_sum[port]   = '0;
        sect_count[port] = 0;
        decide           = 1'b1;
      end
    end
    if (decide && debounce(port, level, now)) r = '{1'b1, port, level};
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_hold();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CFG_W'($urandom_range(0, 65535));
    return CFG_W'($urandom_range(0, 40));
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_count++;
  endtask

  // one input word; valid stays high across back-to-back words
  task automatic send_word(logic [FUNC_W-1:0] func, logic [PORT_W-1:0] port,
                           logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= func;
    in_ch.port   <= port;
    in_ch.sample <= smp;
    in_ch.now_ms <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_reports.push_back(predict_report(func, port, smp, now));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(logic mode, logic [CFG_W-1:0] cur,
                              logic [CFG_W-1:0] f2s, logic [CFG_W-1:0] s2f);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SENSE_MODE;
    cfg_wdata <= CFG_W'(mode);
    @(posedge clk);
    mode_sense = mode;
    cfg_index <= REG_SET_CURRENT;
    cfg_wdata <= cur;
    @(posedge clk);
    thr_current = cur;
    cfg_index <= REG_FREE_TO_SET;
    cfg_wdata <= f2s;
    @(posedge clk);
    hold_set = f2s;
    cfg_index <= REG_SET_TO_FREE;
    cfg_wdata <= s2f;
    @(posedge clk);
    hold_free = s2f;
    cfg_we <= 1'b0;
  endtask

  task automatic test_digital_debounce();
    apply_config(1'b0, SET_CURRENT_RST, 16'd5, 16'd20);
    send_word(FUNC_SAMPLE, 3'd0, 12'h001, 32'd100);
    send_word(FUNC_SAMPLE, 3'd0, 12'hFFF, 32'd105);  // exactly at the delay: held
    send_word(FUNC_SAMPLE, 3'd0, 12'h001, 32'd106);
    send_word(FUNC_SAMPLE, 3'd0, 12'hFFE, 32'd300);
    send_word(FUNC_SAMPLE, 3'd0, 12'h000, 32'd321);
    send_word(FUNC_CALIBRATE, 3'd7, 12'hFFF, 32'hFFFF_FFFF);
    send_word(FUNC_SAMPLE, 3'd7, 12'h001, 32'hFFFF_FFF0);
    send_word(FUNC_SAMPLE, 3'd7, 12'h001, 32'h0000_0010);  // time wrapped: no report
    send_word(FUNC_SAMPLE, 3'd7, 12'h001, 32'hFFFF_FFFF);
    apply_config(1'b0, 16'd0, 16'd0, 16'hFFFF);
    send_word(FUNC_SAMPLE, 3'd3, 12'h001, 32'd50);
    send_word(FUNC_SAMPLE, 3'd3, 12'h001, 32'd51);
    send_word(FUNC_SAMPLE, 3'd3, 12'h000, 32'd52);
    send_word(FUNC_SAMPLE, 3'd3, 12'h000, 32'hFFFF_FFFF);
  endtask

  // full-scale deviation on every sample gives the largest sum, just above
  // the threshold; the wrapped hold time fires at once
  task automatic test_sense_saturation();
    apply_config(1'b1, 16'd227, 16'd1, 16'd0);
    send_word(FUNC_CALIBRATE, 3'd2, 12'hFFF, 32'd0);
    for (int i = 0; i < AVG_LENGTH - 1; i++) send_word(FUNC_SAMPLE, 3'd2, 12'h000, 32'(i));
    send_word(FUNC_SAMPLE, 3'd2, 12'h000, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    logic                mode;
    logic [CFG_W-1:0]    cur;
    logic [CFG_W-1:0]    f2s;
    logic [CFG_W-1:0]    s2f;
    logic [PORT_W-1:0]   hot_a;
    logic [PORT_W-1:0]   hot_b;
    logic [PORT_W-1:0]   port;
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0] off;
    int                  r;
    int                  v;
    for (int ph = 0; ph < 8; ph++) begin
      mode = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      r    = $urandom_range(0, 9);
      cur  = (r == 0) ? '0 : (r == 1) ? '1 : CFG_W'($urandom_range(1, 110));
      f2s  = pick_hold();
      s2f  = pick_hold();
      if (ph == 2) begin
        f2s = '0;
        s2f = '1;
      end
      if (ph == 3) begin
        f2s = '1;
        s2f = '0;
        cur = '1;
      end
      if (ph == 6) cur = '0;
      if (ph == 5) clock_ms = 32'hFFFF_FF00;
      apply_config(mode, cur, f2s, s2f);
      hot_a = PORT_W'($urandom_range(0, SECTIONS - 1));
      hot_b = PORT_W'($urandom_range(0, SECTIONS - 1));
      for (int n = 0; n < 150; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 119) == 0) drain_results();
        if ($urandom_range(0, 9) < 7) port = $urandom_range(0, 1) ? hot_a : hot_b;
        else port = PORT_W'($urandom_range(0, SECTIONS - 1));
        func = ($urandom_range(0, 15) == 0) ? FUNC_CALIBRATE : FUNC_SAMPLE;
        if (func == FUNC_CALIBRATE || $urandom_range(0, 7) == 0) begin
          smp = SAMPLE_W'($urandom_range(0, 4095));
        end else if (!mode) begin
          // frequent flips give glitches shorter than the hold time
          if ($urandom_range(0, 5) == 0) sect_goal[port] = ~sect_goal[port];
          smp = {11'($urandom), sect_goal[port]};
        end else begin
          if ($urandom_range(0, 39) == 0) sect_goal[port] = ~sect_goal[port];
          off = sect_offset[port];
          if (sect_goal[port]) begin
            smp = (off >= 12'd2048) ? SAMPLE_W'($urandom_range(0, 150))
                                    : SAMPLE_W'($urandom_range(3945, 4095));
          end else begin
            r = $urandom_range(0, 24);
            v = int'(off) + r - 12;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            smp = SAMPLE_W'(v);
          end
        end
        r = $urandom_range(0, 99);
        if (r < 90) clock_ms = clock_ms + TIME_W'($urandom_range(0, 5));
        else if (r < 97) clock_ms = clock_ms + TIME_W'($urandom_range(0, 200));
        else clock_ms = TIME_W'($urandom);
        send_word(func, port, smp, clock_ms);
      end
      no_idle = 1'b0;
    end
  endtask

  // result sink: random stalls, with long stretches of steady ready
  initial begin
    int run;
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    report_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("result word with nothing pending: rv=%0b port=%0d occ=%0b",
                                out_ch.report_valid, out_ch.report_port, out_ch.occupied));
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.report_valid !== want.report_valid)
          flag_mismatch($sformatf("report_valid got %0b want %0b",
                                  out_ch.report_valid, want.report_valid));
        if (out_ch.report_port !== want.report_port)
          flag_mismatch($sformatf("report_port got %0d want %0d",
                                  out_ch.report_port, want.report_port));
        if (out_ch.occupied !== want.occupied)
          flag_mismatch($sformatf("occupied got %0b want %0b",
                                  out_ch.occupied, want.occupied));
      end
    end
  end

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_SAMPLE;
    in_ch.port   <= '0;
    in_ch.sample <= '0;
    in_ch.now_ms <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_SENSE_MODE;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    err_count   = 0;
    no_idle     = 1'b0;
    clock_ms    = '0;
    sect_goal   = '0;
    mode_sense  = SENSE_MODE_RST;
    thr_current = SET_CURRENT_RST;
    hold_set    = FREE_TO_SET_RST;
    hold_free   = SET_TO_FREE_RST;
    for (int i = 0; i < SECTIONS; i++) begin
      sect_offset[i]  = '0;
      sect_sum[i]     = '0;
      sect_count[i]   = 0;
      sect_raw[i]     = 1'b0;
      sect_settled[i] = 1'b1;
      sect_stamp[i]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_digital_debounce();
    test_sense_saturation();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tod_pkg.sv
rtl/core/tod_in_if.sv
rtl/core/tod_out_if.sv
rtl/core/track_occupancy_detector.sv
test/tb_track_occupancy_detector.sv
